FILE: hdl/cauchy_erasure_parity_encoder_assert.svh
// Assertion macros for the Cauchy parity encoder.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef CAUCHY_ERASURE_PARITY_ENCODER_ASSERT_SVH
`define CAUCHY_ERASURE_PARITY_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS
// Check held off while reset is asserted.
`define CEPE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that also runs through reset.
`define CEPE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CEPE_ASSERT(lbl, clk, rst_n, prop, msg)
`define CEPE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: hdl/cepe_pkg.sv
// Shared types, constants and GF(2^8) helpers for the Cauchy parity encoder.
// No dependencies.
package cepe_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SHARD_W   = 5;
  localparam int unsigned DCOUNT_W  = 6;
  localparam int unsigned PCOUNT_W  = 5;
  localparam int unsigned PIDX_W    = 4;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_COUNT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_COUNT = 8'd1;

  localparam logic [DCOUNT_W-1:0] DATA_COUNT_RST   = 6'd4;
  localparam logic [PCOUNT_W-1:0] PARITY_COUNT_RST = 5'd2;

  localparam logic [8:0]  GF_POLY  = 9'h11D;
  localparam logic [8:0]  GF_TOP   = 9'h100;
  localparam int unsigned GF_ORDER = 255;

  typedef logic [BYTE_W-1:0] gf_tbl_t [256];

  // Snapshot hand-over from the accumulators to the drain
  typedef struct packed {
    logic                load;
    logic [PCOUNT_W-1:0] last_idx;
  } snap_ctrl_t;

  function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b);
    logic [8:0]        x;
    logic [BYTE_W-1:0] y;
    logic [BYTE_W-1:0] r;
    x = {1'b0, a};
    y = b;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (y[0]) begin
        r = r ^ x[7:0];
      end
      x = {x[7:0], 1'b0};
      if ((x & GF_TOP) != 9'd0) begin
        x = x ^ GF_POLY;
      end
      y = {1'b0, y[7:1]};
    end
    return r;
  endfunction

  // Inverse table from the powers of the generator 2; zero maps to zero.
  function automatic gf_tbl_t build_inv_table();
    logic [BYTE_W-1:0] expv [GF_ORDER];
    logic [8:0]        x;
    gf_tbl_t           t;
    for (int i = 0; i < 256; i++) begin
      t[i] = '0;
    end
    x = 9'd1;
    for (int i = 0; i < GF_ORDER; i++) begin
      expv[i] = x[7:0];
      x = {x[7:0], 1'b0};
      if ((x & GF_TOP) != 9'd0) begin
        x = x ^ GF_POLY;
      end
    end
    for (int i = 0; i < GF_ORDER; i++) begin
      t[expv[i]] = (i == 0) ? expv[0] : expv[GF_ORDER - i];
    end
    return t;
  endfunction

  localparam gf_tbl_t GF_INV = build_inv_table();

endpackage

FILE: hdl/cepe_if.sv
// Valid/ready channel interfaces: data bytes in, parity bytes out, register writes.
// Depends on cepe_pkg for field widths.
interface cepe_in_if;
  logic                           valid;
  logic                           ready;
  logic [cepe_pkg::BYTE_W-1:0]    data_byte;
  logic [cepe_pkg::SHARD_W-1:0]   shard_index;
  modport source (output valid, output data_byte, output shard_index, input ready);
  modport sink   (input valid, input data_byte, input shard_index, output ready);
endinterface

interface cepe_out_if;
  logic                          valid;
  logic                          ready;
  logic [cepe_pkg::BYTE_W-1:0]   parity_byte;
  logic [cepe_pkg::PIDX_W-1:0]   parity_index;
  logic                          last;
  modport source (output valid, output parity_byte, output parity_index, output last,
                  input ready);
  modport sink   (input valid, input parity_byte, input parity_index, input last,
                  output ready);
endinterface

interface cepe_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cepe_pkg::CFG_IDX_W-1:0]   index;
  logic [cepe_pkg::CFG_DAT_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/cepe_drain.sv
// Parity drain: snapshots a finished column; one beat out a cycle while ready is high.
// Depends on cepe_pkg, cepe_if and the assertion macro header.
`include "cauchy_erasure_parity_encoder_assert.svh"

module cepe_drain #(
  parameter int unsigned MAX_PARITY = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cepe_pkg::snap_ctrl_t        ctrl_i,
  input  logic [cepe_pkg::BYTE_W-1:0] snap_i [MAX_PARITY],
  output logic                        free_o,
  cepe_out_if.source                  parity_o
);

  logic [cepe_pkg::BYTE_W-1:0]   snap_q [MAX_PARITY];
  logic [cepe_pkg::BYTE_W-1:0]   snap_d [MAX_PARITY];
  logic                          drain_active_q, drain_active_d;
  logic [cepe_pkg::PCOUNT_W-1:0] ptr_q, ptr_d;
  logic [cepe_pkg::PCOUNT_W-1:0] last_idx_q, last_idx_d;
  logic                          out_valid_q, out_valid_d;
  logic [cepe_pkg::BYTE_W-1:0]   out_byte_q;
  logic [cepe_pkg::PIDX_W-1:0]   out_idx_q;
  logic                          out_last_q;
  logic                          out_load;
  logic                          is_last;

  assign out_load = drain_active_q && (!out_valid_q || parity_o.ready);
  assign is_last  = (ptr_q == last_idx_q);
  // The snapshot may be refilled in the cycle its last beat moves out
  assign free_o   = !drain_active_q || (out_load && is_last);

  always_comb begin
    snap_d         = snap_q;
    drain_active_d = drain_active_q;
    ptr_d          = ptr_q;
    last_idx_d     = last_idx_q;
    out_valid_d    = out_valid_q;
    if (parity_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      for (int i = 0; i < int'(MAX_PARITY) - 1; i++) begin
        snap_d[i] = snap_q[i+1];
      end
      ptr_d = ptr_q + 1'b1;
      if (is_last) begin
        drain_active_d = 1'b0;
      end
    end
    if (ctrl_i.load) begin
      snap_d         = snap_i;
      drain_active_d = 1'b1;
      ptr_d          = '0;
      last_idx_d     = ctrl_i.last_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_active_q <= 1'b0;
      ptr_q          <= '0;
      last_idx_q     <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      drain_active_q <= drain_active_d;
      ptr_q          <= ptr_d;
      last_idx_q     <= last_idx_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
    if (out_load) begin
      out_byte_q <= snap_q[0];
      out_idx_q  <= cepe_pkg::PIDX_W'(ptr_q);
      out_last_q <= is_last;
    end
  end

  assign parity_o.valid        = out_valid_q;
  assign parity_o.parity_byte  = out_byte_q;
  assign parity_o.parity_index = out_idx_q;
  assign parity_o.last         = out_last_q;

  `CEPE_ASSERT(a_load_only_when_free, clk_i, rst_ni, ctrl_i.load |-> free_o, "snapshot overwritten mid drain")
  `CEPE_ASSERT(a_drain_continues, clk_i, rst_ni, (out_load && !is_last) |=> drain_active_q, "drain stopped early")
  `CEPE_ASSERT(a_ptr_in_range, clk_i, rst_ni, drain_active_q |-> (ptr_q <= last_idx_q), "drain pointer past last row")
  `CEPE_ASSERT(a_load_restarts, clk_i, rst_ni, ctrl_i.load |=> (drain_active_q && ptr_q == '0), "drain not restarted on load")

endmodule

FILE: hdl/cauchy_erasure_parity_encoder.sv
// Top level of the Cauchy erasure parity encoder over GF(2^8).
// Depends on cepe_pkg, cepe_if and cepe_drain.
//
// Usage:
//   data_i   : one data byte a beat with its shard index. Indices at or above
//              data_count are dropped; the beat for index data_count-1 closes
//              the column.
//   parity_o : parity_count beats per closed column, rows in order, last set on
//              the final row. Accumulators clear when the column closes.
//   cfg_i    : register writes, always ready; index 0 is data_count, index 1
//              parity_count. Write only while the block is idle.
// Throughput: one data beat per cycle unless the input register is held. Each row has
// its own inverse lookup and GF multiplier, so all active accumulators update together
// as the beat leaves the input register. The closing data beat passes the input
// register, the drain snapshot and the output register; then one parity beat per cycle
// while the receiver is ready. The drain holds one column snapshot, so a closing beat
// waits in the input register while more than one beat of the previous column is
// still to go; with data_count >= parity_count the input never stalls for this reason.
// Reset: accumulators clear, data_count = 4, parity_count = 2, nothing valid.
// Stall: a held output keeps its beat; the drain and then the input back up.
module cauchy_erasure_parity_encoder #(
  parameter int unsigned MAX_DATA   = 32,
  parameter int unsigned MAX_PARITY = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cepe_cfg_if.sink   cfg_i,
  cepe_in_if.sink    data_i,
  cepe_out_if.source parity_o
);

  logic [cepe_pkg::DCOUNT_W-1:0] data_count_q;
  logic [cepe_pkg::PCOUNT_W-1:0] parity_count_q;
  logic [cepe_pkg::DCOUNT_W-1:0] k_eff;
  logic [cepe_pkg::PCOUNT_W-1:0] m_eff;

  logic                          s1_valid_q;
  logic [cepe_pkg::BYTE_W-1:0]   s1_byte_q;
  logic [cepe_pkg::SHARD_W-1:0]  s1_shard_q;
  logic                          s1_member;
  logic                          s1_emit;
  logic                          s1_fire;
  logic                          in_beat;
  logic [cepe_pkg::DCOUNT_W-1:0] coeff_base;

  logic [cepe_pkg::BYTE_W-1:0]   acc_q   [MAX_PARITY];
  logic [cepe_pkg::BYTE_W-1:0]   acc_d   [MAX_PARITY];
  logic [cepe_pkg::BYTE_W-1:0]   acc_sum [MAX_PARITY];
  logic [cepe_pkg::BYTE_W-1:0]   prod    [MAX_PARITY];
  logic [MAX_PARITY-1:0]         row_on;

  cepe_pkg::snap_ctrl_t          snap_ctrl;
  logic                          snap_free;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_count_q   <= cepe_pkg::DATA_COUNT_RST;
      parity_count_q <= cepe_pkg::PARITY_COUNT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        cepe_pkg::CFG_DATA_COUNT:   data_count_q   <= cfg_i.data[cepe_pkg::DCOUNT_W-1:0];
        cepe_pkg::CFG_PARITY_COUNT: parity_count_q <= cfg_i.data[cepe_pkg::PCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero acts as one, large values saturate at the build limit
  always_comb begin
    if (data_count_q == '0) begin
      k_eff = cepe_pkg::DCOUNT_W'(1);
    end else if (32'(data_count_q) > 32'(MAX_DATA)) begin
      k_eff = cepe_pkg::DCOUNT_W'(MAX_DATA);
    end else begin
      k_eff = data_count_q;
    end
    if (parity_count_q == '0) begin
      m_eff = cepe_pkg::PCOUNT_W'(1);
    end else if (32'(parity_count_q) > 32'(MAX_PARITY)) begin
      m_eff = cepe_pkg::PCOUNT_W'(MAX_PARITY);
    end else begin
      m_eff = parity_count_q;
    end
  end

  // Input register
  assign in_beat      = data_i.valid && data_i.ready;
  assign s1_member    = {1'b0, s1_shard_q} < k_eff;
  assign s1_emit      = s1_member && ({1'b0, s1_shard_q} == (k_eff - 1'b1));
  assign s1_fire      = s1_valid_q && (!s1_emit || snap_free);
  assign data_i.ready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (data_i.ready) begin
      s1_valid_q <= data_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_byte_q  <= data_i.data_byte;
      s1_shard_q <= data_i.shard_index;
    end
  end

  // One coefficient lookup and multiplier per parity row
  assign coeff_base = {1'b0, m_eff} + {1'b0, s1_shard_q};

  for (genvar p = 0; p < int'(MAX_PARITY); p++) begin : g_row
    localparam logic [cepe_pkg::BYTE_W-1:0] ROW = cepe_pkg::BYTE_W'(p);
    logic [cepe_pkg::BYTE_W-1:0] coeff;
    assign row_on[p] = ROW < {3'b0, m_eff};
    assign coeff     = (m_eff == cepe_pkg::PCOUNT_W'(1)) ? cepe_pkg::BYTE_W'(1) :
                       cepe_pkg::GF_INV[ROW ^ {2'b0, coeff_base}];
    assign prod[p]    = cepe_pkg::gf_mul(s1_byte_q, coeff);
    assign acc_sum[p] = row_on[p] ? (acc_q[p] ^ prod[p]) : acc_q[p];
  end

  always_comb begin
    acc_d = acc_q;
    if (s1_fire && s1_member) begin
      for (int i = 0; i < int'(MAX_PARITY); i++) begin
        acc_d[i] = s1_emit ? '0 : acc_sum[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(MAX_PARITY); i++) begin
        acc_q[i] <= '0;
      end
    end else begin
      acc_q <= acc_d;
    end
  end

  // Closing beat hands the finished column to the drain
  assign snap_ctrl.load     = s1_fire && s1_emit;
  assign snap_ctrl.last_idx = m_eff - 1'b1;

  cepe_drain #(
    .MAX_PARITY (MAX_PARITY)
  ) u_drain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (snap_ctrl),
    .snap_i   (acc_sum),
    .free_o   (snap_free),
    .parity_o (parity_o)
  );

endmodule

FILE: dv/cauchy_erasure_parity_encoder_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the Cauchy GF(2^8) parity encoder: a scoreboard predicts
// every parity beat from the data beats taken and checks them in order.
// Depends on cepe_pkg, the cepe_if channel interfaces and the encoder RTL.
module cauchy_erasure_parity_encoder_tb;

  localparam int unsigned MAX_DATA      = 32;
  localparam int unsigned MAX_PARITY    = 16;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_BEATS  = 120;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [cepe_pkg::BYTE_W-1:0] pbyte;
    logic [cepe_pkg::PIDX_W-1:0] pidx;
    logic                        last;
  } parity_beat_t;

  class parity_scoreboard;
    logic [cepe_pkg::BYTE_W-1:0]   acc [MAX_PARITY];
    logic [cepe_pkg::BYTE_W-1:0]   recip [256];
    logic [cepe_pkg::DCOUNT_W-1:0] data_cnt;
    logic [cepe_pkg::PCOUNT_W-1:0] par_cnt;
    parity_beat_t                  parity_due [$];
    int unsigned                   errors;

    function new();
      foreach (acc[i]) acc[i] = '0;
      data_cnt = cepe_pkg::DATA_COUNT_RST;
      par_cnt  = cepe_pkg::PARITY_COUNT_RST;
      errors   = 0;
      // brute-force reciprocal table, zero has none and stays zero
      for (int a = 0; a < 256; a++) begin
        recip[a] = '0;
        for (int b = 1; b < 256; b++) begin
          if (gf_times(a[7:0], b[7:0]) == 8'd1) recip[a] = b[7:0];
        end
      end
    endfunction

    function logic [cepe_pkg::BYTE_W-1:0] gf_times(logic [cepe_pkg::BYTE_W-1:0] a,
                                                   logic [cepe_pkg::BYTE_W-1:0] b);
      logic [cepe_pkg::BYTE_W-1:0] prod;
      logic [cepe_pkg::BYTE_W-1:0] x;
      prod = '0;
      x    = a;
      for (int i = 0; i < cepe_pkg::BYTE_W; i++) begin
        if (b[i]) prod ^= x;
        x = x[7] ? ((x << 1) ^ cepe_pkg::GF_POLY[7:0]) : (x << 1);
      end
      return prod;
    endfunction

    function int unsigned eff_k();
      if (data_cnt == 0) return 1;
      if (data_cnt > MAX_DATA) return MAX_DATA;
      return data_cnt;
    endfunction

    function int unsigned eff_m();
      if (par_cnt == 0) return 1;
      if (par_cnt > MAX_PARITY) return MAX_PARITY;
      return par_cnt;
    endfunction

    function void write_register(logic [cepe_pkg::CFG_IDX_W-1:0] idx,
                                 logic [cepe_pkg::CFG_DAT_W-1:0] val);
      if (idx == cepe_pkg::CFG_DATA_COUNT) data_cnt = val[cepe_pkg::DCOUNT_W-1:0];
      else if (idx == cepe_pkg::CFG_PARITY_COUNT) par_cnt = val[cepe_pkg::PCOUNT_W-1:0];
    endfunction

    function void absorb_byte(logic [cepe_pkg::BYTE_W-1:0] db,
                              logic [cepe_pkg::SHARD_W-1:0] shard);
      int unsigned                 k;
      int unsigned                 m;
      logic [cepe_pkg::BYTE_W-1:0] coeff;
      logic [cepe_pkg::BYTE_W-1:0] row_key;
      parity_beat_t                beat;
      k = eff_k();
      m = eff_m();
      if (shard >= k) return;
      for (int unsigned p = 0; p < m; p++) begin
        row_key = 8'(p ^ (m + shard));
        coeff   = (m == 1) ? 8'd1 : recip[row_key];
        acc[p] ^= gf_times(db, coeff);
      end
      if (shard != k - 1) return;
      for (int unsigned p = 0; p < m; p++) begin
        beat.pbyte = acc[p];
        beat.pidx  = p[cepe_pkg::PIDX_W-1:0];
        beat.last  = (p == m - 1);
        parity_due.push_back(beat);
      end
      foreach (acc[i]) acc[i] = '0;
    endfunction

    task report(string what);
      $display("[%0t] parity check: %s", $time, what);
      errors++;
    endtask

    task check_parity(parity_beat_t got);
      parity_beat_t want;
      if (parity_due.size() == 0) begin
        report($sformatf("beat with nothing outstanding, byte %02h row %0d",
                         got.pbyte, got.pidx));
        return;
      end
      want = parity_due.pop_front();
      if (got.pbyte !== want.pbyte)
        report($sformatf("row %0d byte %02h, want %02h", want.pidx, got.pbyte, want.pbyte));
      if (got.pidx !== want.pidx)
        report($sformatf("row index %0d, want %0d", got.pidx, want.pidx));
      if (got.last !== want.last)
        report($sformatf("row %0d last %b, want %b", want.pidx, got.last, want.last));
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  int unsigned      cycle_count;
  int unsigned      burst_left;
  bit               src_busy;
  bit               sink_busy;
  parity_scoreboard enc_sb;

  cepe_in_if  data_if ();
  cepe_out_if parity_if ();
  cepe_cfg_if cfg_if ();

  cauchy_erasure_parity_encoder u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if),
    .data_i   (data_if),
    .parity_o (parity_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: runs of ready high or low, always high while the sink is not busy
  initial begin
    int unsigned stall_run;
    logic        stall_lvl;
    stall_run = 0;
    stall_lvl = 1'b1;
    parity_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_run == 0) begin
        stall_run = $urandom_range(1, 6);
        stall_lvl = sink_busy ? 1'($urandom_range(0, 1)) : 1'b1;
      end
      stall_run--;
      parity_if.ready <= stall_lvl;
    end
  end

  always @(posedge clk_i) begin
    parity_beat_t got;
    if (rst_ni && parity_if.valid === 1'b1 && parity_if.ready === 1'b1) begin
      got.pbyte = parity_if.parity_byte;
      got.pidx  = parity_if.parity_index;
      got.last  = parity_if.last;
      enc_sb.check_parity(got);
    end
  end

  // valid is left high; the caller lowers it once the whole group is written
  task automatic write_reg(input logic [cepe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cepe_pkg::CFG_DAT_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    enc_sb.write_register(idx, val);
    @(negedge clk_i);
  endtask

  task automatic apply_config(input logic [cepe_pkg::CFG_DAT_W-1:0] dc,
                              input logic [cepe_pkg::CFG_DAT_W-1:0] pc,
                              input bit swap, input bit stray);
    if (stray) write_reg(cepe_pkg::CFG_IDX_W'($urandom_range(2, 255)),
                         cepe_pkg::CFG_DAT_W'($urandom));
    if (swap) begin
      write_reg(cepe_pkg::CFG_PARITY_COUNT, pc);
      write_reg(cepe_pkg::CFG_DATA_COUNT, dc);
    end else begin
      write_reg(cepe_pkg::CFG_DATA_COUNT, dc);
      write_reg(cepe_pkg::CFG_PARITY_COUNT, pc);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_beat(input logic [cepe_pkg::BYTE_W-1:0] db,
                           input logic [cepe_pkg::SHARD_W-1:0] shard);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = src_busy ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
        data_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    data_if.valid       <= 1'b1;
    data_if.data_byte   <= db;
    data_if.shard_index <= shard;
    do @(posedge clk_i); while (data_if.ready !== 1'b1);
    enc_sb.absorb_byte(db, shard);
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic end_burst();
    data_if.valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_idle();
    while (enc_sb.parity_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // every shard once in random order, closing shard last
  task automatic send_column(input int unsigned k);
    int unsigned order [MAX_DATA];
    int unsigned j;
    int unsigned t;
    for (int unsigned i = 0; i + 1 < k; i++) order[i] = i;
    for (int i = int'(k) - 2; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int unsigned i = 0; i + 1 < k; i++) begin
      send_beat(8'($urandom), cepe_pkg::SHARD_W'(order[i]));
    end
    send_beat(8'($urandom), cepe_pkg::SHARD_W'(k - 1));
  endtask

  // any index at all: foreign, repeated, missing or an early close
  task automatic send_noise(input int unsigned k, output int unsigned hits);
    int unsigned n;
    int unsigned shard;
    hits = 0;
    n = $urandom_range(1, 6);
    repeat (n) begin
      shard = $urandom_range(0, 31);
      if (shard < k) hits++;
      send_beat(8'($urandom), cepe_pkg::SHARD_W'(shard));
    end
  endtask

  initial begin
    int unsigned                    taken;
    int unsigned                    k;
    int unsigned                    cols;
    int unsigned                    sel;
    int unsigned                    hits;
    logic [cepe_pkg::CFG_DAT_W-1:0] dc;
    logic [cepe_pkg::CFG_DAT_W-1:0] pc;

    enc_sb     = new();
    burst_left = 0;
    src_busy   = 1'b1;
    sink_busy  = 1'b1;
    rst_ni     = 1'b0;
    data_if.valid       = 1'b0;
    data_if.data_byte   = '0;
    data_if.shard_index = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset counts: four shards, two rows; byte extremes, then foreign and repeats
    send_beat(8'h00, 5'd0);
    send_beat(8'hFF, 5'd1);
    send_beat(8'h80, 5'd2);
    send_beat(8'h01, 5'd3);
    send_beat(8'hAA, 5'd31);
    send_beat(8'h5A, 5'd0);
    send_beat(8'h5A, 5'd0);
    send_beat(8'h3C, 5'd3);
    end_burst();
    wait_idle();

    // zero counts act as one: every shard-0 beat closes a single-row column
    apply_config(8'd0, 8'd0, 1'b0, 1'b0);
    send_beat(8'hFF, 5'd0);
    send_beat(8'h01, 5'd0);
    send_beat(8'h77, 5'd5);
    end_burst();
    wait_idle();

    apply_config(8'd1, 8'd16, 1'b1, 1'b1);
    send_beat(8'hC3, 5'd0);
    end_burst();
    wait_idle();

    // oversized counts clamp to the maximum
    apply_config(8'hFF, 8'hFF, 1'b0, 1'b0);
    send_beat(8'h96, 5'd17);
    send_beat(8'h69, 5'd30);
    send_beat(8'hE7, 5'd31);
    end_burst();
    wait_idle();

    // partial column carried across a change of counts
    apply_config(8'd3, 8'd3, 1'b0, 1'b0);
    send_beat(8'h12, 5'd0);
    send_beat(8'h34, 5'd1);
    end_burst();
    wait_idle();
    apply_config(8'd2, 8'd5, 1'b1, 1'b0);
    send_beat(8'hF0, 5'd1);
    end_burst();
    wait_idle();

    taken = 0;
    while (taken < RANDOM_BEATS) begin
      sel = $urandom_range(0, 11);
      if (sel == 0) begin
        dc = cepe_pkg::CFG_DAT_W'($urandom);
        pc = cepe_pkg::CFG_DAT_W'($urandom);
      end else if (sel == 1) begin
        dc = cepe_pkg::CFG_DAT_W'(MAX_DATA);
        pc = cepe_pkg::CFG_DAT_W'(MAX_PARITY);
      end else begin
        dc = cepe_pkg::CFG_DAT_W'($urandom_range(1, 6));
        pc = cepe_pkg::CFG_DAT_W'($urandom_range(1, 16));
      end
      apply_config(dc, pc, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
      src_busy  = $urandom_range(0, 3) != 0;
      sink_busy = $urandom_range(0, 3) != 0;
      k    = enc_sb.eff_k();
      cols = (k > 8) ? 1 : $urandom_range(1, 3);
      repeat (cols) begin
        if ($urandom_range(0, 4) != 0) begin
          send_column(k);
          taken += k;
        end else begin
          send_noise(k, hits);
          taken += hits;
        end
      end
      end_burst();
      wait_idle();
    end

    repeat (2 * SETTLE_CYCLES) @(negedge clk_i);
    if (enc_sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/cepe_pkg.sv
hdl/cepe_if.sv
hdl/cepe_drain.sv
hdl/cauchy_erasure_parity_encoder.sv
dv/cauchy_erasure_parity_encoder_tb.sv
